/* hdl/biquad_cascade_filter_macros.svh */
// Assertion macros for the biquad cascade filter.
// No dependencies; included by the top level only.
`ifndef BIQUAD_CASCADE_FILTER_MACROS_SVH
`define BIQUAD_CASCADE_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bcf_pkg.sv */
// Shared constants, control word type and microcode program for the biquad cascade.
// No dependencies; imported by bcf_seq and biquad_cascade_filter.
`timescale 1ns / 1ps
`default_nettype none

package bcf_pkg;

   localparam int COEF_BITS       = 24;
   localparam int DELAY_BITS      = 48;
   localparam int REG_BITS        = 2 * COEF_BITS;
   localparam int REG_COUNT       = 5;
   localparam int CSR_ADDR_W      = 3;
   localparam int STORED_SECTIONS = 2;
   localparam int SEC_IDX_W       = 1;
   localparam int PC_W            = 3;

   // register indexes, also the coefficient select codes of the microcode
   localparam logic [CSR_ADDR_W-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_A2 = 3'd4;

   // multiplier operand select
   localparam logic OPND_X = 1'b0;
   localparam logic OPND_Y = 1'b1;

   // accumulator operations
   localparam logic [2:0] ACC_HOLD      = 3'd0;
   localparam logic [2:0] ACC_LOAD_Z0   = 3'd1;
   localparam logic [2:0] ACC_ADD_P     = 3'd2;
   localparam logic [2:0] ACC_LOAD_Z1_P = 3'd3;
   localparam logic [2:0] ACC_SUB_P     = 3'd4;
   localparam logic [2:0] ACC_LOAD_P    = 3'd5;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] coef_sel;
      logic                  opnd_sel;
      logic [2:0]            acc_op;
      logic                  wr_y;
      logic                  wr_z0;
      logic                  wr_z1;
      logic                  end_sec;   // branch to target if sections remain, else finish
      logic [PC_W-1:0]       target;
   } ucode_type;

   typedef struct packed {
      ucode_type              cw;
      logic [SEC_IDX_W-1:0]   sec;
      logic                   exec;     // current word takes effect this cycle
      logic                   finish;   // last word of the last section executes
      logic                   busy;
   } bcf_ctrl_type;

   // One section, eight steps. The product register lags by one step:
   // the accumulator op of step k uses the product chosen in step k-1.
   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{coef_sel: REG_B0, opnd_sel: OPND_X, acc_op: ACC_HOLD, wr_y: 1'b0,
            wr_z0: 1'b0, wr_z1: 1'b0, end_sec: 1'b0, target: '0};
      case (pc)
         3'd0: begin                       // p = b0*x, acc = z0
            w.coef_sel = REG_B0;
            w.acc_op   = ACC_LOAD_Z0;
         end
         3'd1: begin                       // p = b1*x, acc = b0*x + z0
            w.coef_sel = REG_B1;
            w.acc_op   = ACC_ADD_P;
         end
         3'd2: begin                       // y = sat(round(acc)), acc = b1*x + z1
            w.coef_sel = REG_B2;
            w.acc_op   = ACC_LOAD_Z1_P;
            w.wr_y     = 1'b1;
         end
         3'd3: begin                       // p = a1*y
            w.coef_sel = REG_A1;
            w.opnd_sel = OPND_Y;
            w.acc_op   = ACC_HOLD;
         end
         3'd4: begin                       // p = b2*x, acc -= a1*y
            w.coef_sel = REG_B2;
            w.acc_op   = ACC_SUB_P;
         end
         3'd5: begin                       // p = a2*y, z0 = sat(acc), acc = b2*x
            w.coef_sel = REG_A2;
            w.opnd_sel = OPND_Y;
            w.acc_op   = ACC_LOAD_P;
            w.wr_z0    = 1'b1;
         end
         3'd6: begin                       // acc -= a2*y
            w.acc_op   = ACC_SUB_P;
         end
         3'd7: begin                       // z1 = sat(acc), next section or done
            w.wr_z1    = 1'b1;
            w.end_sec  = 1'b1;
            w.target   = 3'd0;
         end
         default: begin
            w.acc_op   = ACC_HOLD;
         end
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

/* hdl/biquad_cascade_filter.sv */
// Cascaded biquad filter (transposed direct form II), top level and datapath.
// Depends on bcf_pkg, bcf_seq and biquad_cascade_filter_macros.svh.
//
// Usage:
//  - req_*: one signed sample per transfer in req_tdata (zero padded to bytes).
//  - rsp_*: one filtered sample per input in rsp_tdata; rsp_tuser is the clip
//    flag, set when either section's output saturated for that sample.
//  - csr_*: coefficient writes, index 0..4 = b0, b1, b2, a1, a2 pairs
//    (section 1 in bits 23:0, section 2 in bits 47:24). Other indexes ignored.
//    Write only while idle.
//  - Each section runs an 8-step microprogram through one shared multiplier
//    and one accumulator; the result is loaded after the last step of the last
//    section, and req_tready stays low while the sequencer runs, so a new item
//    is taken only once the previous one has finished its run.
//  - The result sits in an output register; req_tready returns as soon as the
//    result is loaded, so the next item runs while the result waits. If the
//    receiver still holds the previous result when the next one is done, the
//    sequencer holds on its final step until rsp_tready.
//  - Reset (synchronous): delays cleared, b0 = 1.0 in both sections, other
//    coefficients 0 (pass-through), no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "biquad_cascade_filter_macros.svh"

module biquad_cascade_filter
   import bcf_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 20,
   parameter int SECTIONS       = 2
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // input channel
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   input  wire logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] req_tdata,  // [SB-1:0] sample_in
   // result channel
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output      logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] rsp_tdata,  // [SB-1:0] sample_out
   output      logic                                   rsp_tuser,  // [0] clipped
   // configuration
   input  wire logic                                   csr_we,
   input  wire logic [CSR_ADDR_W-1:0]                  csr_addr,
   input  wire logic [REG_BITS-1:0]                    csr_wdata
);

   localparam int DATA_W    = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int SEC_COUNT = (SECTIONS >= 2) ? 2 : 1;     // at most two sections, as two are stored
   localparam int MUL_W     = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_W     = ((MUL_W > DELAY_BITS) ? MUL_W : DELAY_BITS) + 2;

   localparam logic [COEF_BITS-1:0] COEF_ONE   = COEF_BITS'(64'd1 << COEF_FRAC_BITS);
   localparam logic [REG_BITS-1:0]  B0_RESET   = {COEF_ONE, COEF_ONE};
   localparam logic [ACC_W-1:0]     ROUND_HALF = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));

   // ---------------------------------------------------------------- sequencer
   bcf_ctrl_type ctrl;
   logic         req_xfer;
   logic         rsp_blocked;

   assign req_tready  = !ctrl.busy;
   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_blocked = rsp_tvalid && !rsp_tready;

   bcf_seq #(
      .SEC_COUNT (SEC_COUNT)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (req_xfer),
      .rsp_blocked (rsp_blocked),
      .ctrl        (ctrl)
   );

   // ------------------------------------------------------ coefficient registers
   logic [REG_BITS-1:0] coef_ff [REG_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[REG_B0] <= B0_RESET;
         coef_ff[REG_B1] <= '0;
         coef_ff[REG_B2] <= '0;
         coef_ff[REG_A1] <= '0;
         coef_ff[REG_A2] <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            REG_B0:  coef_ff[REG_B0] <= csr_wdata;
            REG_B1:  coef_ff[REG_B1] <= csr_wdata;
            REG_B2:  coef_ff[REG_B2] <= csr_wdata;
            REG_A1:  coef_ff[REG_A1] <= csr_wdata;
            REG_A2:  coef_ff[REG_A2] <= csr_wdata;
            default: ;                          // unknown index: ignored
         endcase
      end
   end

   // pick the register named by the control word, then the section half
   logic [REG_BITS-1:0]         coef_pair;
   logic signed [COEF_BITS-1:0] coef_val;

   always_comb begin
      case (ctrl.cw.coef_sel)
         REG_B0:  coef_pair = coef_ff[REG_B0];
         REG_B1:  coef_pair = coef_ff[REG_B1];
         REG_B2:  coef_pair = coef_ff[REG_B2];
         REG_A1:  coef_pair = coef_ff[REG_A1];
         REG_A2:  coef_pair = coef_ff[REG_A2];
         default: coef_pair = '0;
      endcase
   end

   assign coef_val = ctrl.sec[0] ? coef_pair[REG_BITS-1:COEF_BITS]
                                 : coef_pair[COEF_BITS-1:0];

   // ---------------------------------------------------------------- datapath
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;       // section input
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;       // section output
   logic                          clip_ff, clip_in;
   logic signed [MUL_W-1:0]       p_ff, p_in;       // product register
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [DELAY_BITS-1:0]  z_ff [STORED_SECTIONS][2];
   logic signed [SAMPLE_BITS-1:0] opnd_val;
   logic signed [ACC_W-1:0]       p_ext;
   logic signed [ACC_W-1:0]       z0_ext;
   logic signed [ACC_W-1:0]       z1_ext;
   logic signed [ACC_W-1:0]       rounded;
   logic signed [ACC_W-1:0]       shifted;
   logic                          y_ovf;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic                          z_ovf;
   logic signed [DELAY_BITS-1:0]  z_sat;

   assign opnd_val = (ctrl.cw.opnd_sel == OPND_Y) ? y_ff : x_ff;
   assign p_in     = MUL_W'(coef_val) * MUL_W'(opnd_val);

   assign p_ext  = ACC_W'(p_ff);
   assign z0_ext = ACC_W'(z_ff[ctrl.sec][0]);
   assign z1_ext = ACC_W'(z_ff[ctrl.sec][1]);

   always_comb begin
      case (ctrl.cw.acc_op)
         ACC_HOLD:      acc_in = acc_ff;
         ACC_LOAD_Z0:   acc_in = z0_ext;
         ACC_ADD_P:     acc_in = acc_ff + p_ext;
         ACC_LOAD_Z1_P: acc_in = z1_ext + p_ext;
         ACC_SUB_P:     acc_in = acc_ff - p_ext;
         ACC_LOAD_P:    acc_in = p_ext;
         default:       acc_in = acc_ff;
      endcase
   end

   // round half up, floor shift, saturate to the sample range
   assign rounded = acc_ff + ROUND_HALF;
   assign shifted = rounded >>> COEF_FRAC_BITS;
   assign y_ovf   = !((&shifted[ACC_W-1:SAMPLE_BITS-1]) || !(|shifted[ACC_W-1:SAMPLE_BITS-1]));
   assign y_sat   = y_ovf ? {shifted[ACC_W-1], {(SAMPLE_BITS-1){!shifted[ACC_W-1]}}}
                          : shifted[SAMPLE_BITS-1:0];

   // delay words saturate to 48 bits without flagging
   assign z_ovf = !((&acc_ff[ACC_W-1:DELAY_BITS-1]) || !(|acc_ff[ACC_W-1:DELAY_BITS-1]));
   assign z_sat = z_ovf ? {acc_ff[ACC_W-1], {(DELAY_BITS-1){!acc_ff[ACC_W-1]}}}
                        : acc_ff[DELAY_BITS-1:0];

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      clip_in = clip_ff;
      if (req_xfer) begin
         x_in    = req_tdata[SAMPLE_BITS-1:0];
         clip_in = 1'b0;
      end else if (ctrl.exec) begin
         if (ctrl.cw.wr_y) begin
            y_in    = y_sat;
            clip_in = clip_ff || y_ovf;
         end
         if (ctrl.cw.end_sec) begin
            x_in = y_ff;                        // cascade into the next section
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      clip_ff <= clip_in;
      p_ff    <= p_in;
      if (ctrl.exec) begin
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STORED_SECTIONS; s++) begin
            z_ff[s][0] <= '0;
            z_ff[s][1] <= '0;
         end
      end else if (ctrl.exec) begin
         if (ctrl.cw.wr_z0) begin
            z_ff[ctrl.sec][0] <= z_sat;
         end
         if (ctrl.cw.wr_z1) begin
            z_ff[ctrl.sec][1] <= z_sat;
         end
      end
   end

   // ---------------------------------------------------------- result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] out_sample_ff;
   logic                   out_clip_ff;

   always_comb begin
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.finish) begin
         out_sample_ff <= y_ff;
         out_clip_ff   <= clip_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(out_sample_ff);
   assign rsp_tuser  = out_clip_ff;

   // -------------------------------------------------------------- assertions
   `BCF_ASSERT_NEXT(a_xfer_starts_run, clock, reset, req_xfer, ctrl.busy, "run not started")
   `BCF_ASSERT_IMP(a_finish_into_free_reg, clock, reset, ctrl.finish, !rsp_blocked, "result lost")
   `BCF_ASSERT_NEXT(a_finish_shows_result, clock, reset, ctrl.finish, rsp_tvalid, "no result")
   `BCF_ASSERT_IMP(a_idle_no_exec, clock, reset, !ctrl.busy, !ctrl.exec, "exec while idle")

endmodule

`default_nettype wire

/* hdl/bcf_seq.sv */
// Microcode sequencer: step counter, section counter and program table.
// Depends on bcf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcf_seq
   import bcf_pkg::*;
#(
   parameter int SEC_COUNT = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic         rsp_blocked,
   output bcf_ctrl_type      ctrl
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;
   localparam logic [SEC_IDX_W-1:0] SEC_LAST = SEC_IDX_W'(SEC_COUNT - 1);

   logic                 state_ff, state_in;
   logic [PC_W-1:0]      pc_ff, pc_in;
   logic [SEC_IDX_W-1:0] sec_ff, sec_in;
   ucode_type            cw;
   logic                 last_sec;
   logic                 stall;
   logic                 exec;
   logic                 finish;

   assign cw       = ucode_rom(pc_ff);
   assign last_sec = (sec_ff == SEC_LAST);
   // result register still full: hold on the final word
   assign stall    = cw.end_sec && last_sec && rsp_blocked;
   assign exec     = (state_ff == ST_RUN) && !stall;
   assign finish   = exec && cw.end_sec && last_sec;

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      sec_in   = sec_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RUN;
               pc_in    = '0;
               sec_in   = '0;
            end
         end
         ST_RUN: begin
            if (exec) begin
               if (cw.end_sec) begin
                  if (last_sec) begin
                     state_in = ST_IDLE;
                  end else begin
                     sec_in = sec_ff + 1'b1;
                     pc_in  = cw.target;
                  end
               end else begin
                  pc_in = pc_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
         sec_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
         sec_ff   <= sec_in;
      end
   end

   assign ctrl.cw     = cw;
   assign ctrl.sec    = sec_ff;
   assign ctrl.exec   = exec;
   assign ctrl.finish = finish;
   assign ctrl.busy   = (state_ff == ST_RUN);

endmodule

`default_nettype wire
